### design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and microprogram for odometry core
// Holds the control word layout, the datapath select codes, fixed-point
// constants and the microcode table that the sequencer steps through.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // Field widths
    localparam int CFG_W  = 16;  // configuration registers
    localparam int SPD_W  = 17;  // wheel speed sum / difference, signed Q9.8
    localparam int OP_W   = 34;  // multiplier operand width, signed
    localparam int PROD_W = 64;  // kept product bits, signed
    localparam int Z_W    = 32;  // folded angle and its square, Q2.30
    localparam int POS_W  = 32;  // position, signed Q16.16
    localparam int HDG_W  = 16;  // heading output
    localparam int SHA_W  = 6;   // shift amount in the rounder
    localparam int ANG_SHIFT_BASE = 47;  // dang shift is this minus angle bits

    // Register reset values
    localparam logic [CFG_W-1:0] RST_RADIUS = 16'd1966;
    localparam logic [CFG_W-1:0] RST_INVTRK = 16'd18204;
    localparam logic [CFG_W-1:0] RST_TSTEP  = 16'd1507;

    // Fixed-point constants (Q30)
    localparam logic signed [OP_W-1:0] INV_PI_Q30 = 34'sd341782638;
    localparam logic signed [OP_W-1:0] SIN_A      = 34'sd1686629713;
    localparam logic signed [OP_W-1:0] SIN_B      = 34'sd688904866;
    localparam logic signed [OP_W-1:0] SIN_C      = 34'sd76016977;

    // Angle folding limits, 2^30 = pi/2
    localparam logic signed [Z_W:0] HALF_PI_33 = 33'sd1073741824;
    localparam logic signed [Z_W:0] PI_33      = 33'sd2147483648;
    localparam logic [31:0]         QUARTER_TURN = 32'h4000_0000;

    // Position saturation limits
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_INVTRK = 2'd1,
        CFG_TSTEP  = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_seq_state;

    // Microcode program counter
    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] t_upc;
    localparam t_upc UPC_TRIG = 6'd18;  // start of trig / accumulate routine
    localparam t_upc UPC_LOOP = 6'd33;  // end of routine, jumps back once
    localparam t_upc UPC_LAST = 6'd34;  // final step, hands off the word

    // Sequencing op
    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_LOOP,
        SQ_DONE
    } t_sq_op;

    // Multiplier operand A select
    typedef enum logic [2:0] {
        OPA_RADIUS,
        OPA_T,
        OPA_Z,
        OPA_Z2,
        OPA_VD
    } t_opa;

    // Multiplier operand B select
    typedef enum logic [2:0] {
        OPB_DIFF,
        OPB_SUM,
        OPB_INVTRK,
        OPB_TSTEP,
        OPB_INVPI,
        OPB_Z,
        OPB_C,
        OPB_T
    } t_opb;

    // Rounder shift select
    typedef enum logic [2:0] {
        SH_0,
        SH_16,
        SH_17,
        SH_20,
        SH_30,
        SH_38,
        SH_ANG
    } t_shs;

    // Writeback destination
    typedef enum logic [3:0] {
        DST_NONE,
        DST_T,
        DST_HEAD,
        DST_VD,
        DST_FOLD,
        DST_Z2,
        DST_TB,
        DST_TA,
        DST_ACC
    } t_dst;

    // One control word
    typedef struct packed {
        t_sq_op sq;
        t_upc   target;
        logic   mul_en;
        t_opa   opa;
        t_opb   opb;
        logic   sh_en;
        t_shs   shs;
        logic   rnd;
        t_dst   dst;
    } t_uop;

    localparam t_uop UOP_NOP = '{
        sq: SQ_NEXT, target: '0, mul_en: 1'b0, opa: OPA_RADIUS, opb: OPB_DIFF,
        sh_en: 1'b0, shs: SH_0, rnd: 1'b0, dst: DST_NONE
    };

    // Sequencer to datapath control bundle
    typedef struct packed {
        logic load;  // latch the accepted input word
        logic pass;  // 0: cos -> x, 1: sin -> y
        t_uop uop;
    } t_dp_ctl;

    // Control word builders
    function automatic t_uop u_mul(input t_opa a, input t_opb b);
        t_uop u;
        u        = UOP_NOP;
        u.mul_en = 1'b1;
        u.opa    = a;
        u.opb    = b;
        return u;
    endfunction

    function automatic t_uop u_sh(input t_shs s, input logic r);
        t_uop u;
        u       = UOP_NOP;
        u.sh_en = 1'b1;
        u.shs   = s;
        u.rnd   = r;
        return u;
    endfunction

    function automatic t_uop u_dst(input t_dst d);
        t_uop u;
        u     = UOP_NOP;
        u.dst = d;
        return u;
    endfunction

    // Microprogram. Each multiply takes three steps: issue, round, write back.
    function automatic t_uop ddo_ucode(input t_upc pc);
        t_uop u;
        u = UOP_NOP;
        unique case (pc)
            // turn step: p = rnd(R*D*I >> 16)
            6'd0:  u = u_mul(OPA_RADIUS, OPB_DIFF);
            6'd1:  u = u_sh(SH_0, 1'b0);
            6'd2:  u = u_dst(DST_T);
            6'd3:  u = u_mul(OPA_T, OPB_INVTRK);
            6'd4:  u = u_sh(SH_16, 1'b1);
            6'd5:  u = u_dst(DST_T);
            // q = rnd(p*T >> 20)
            6'd6:  u = u_mul(OPA_T, OPB_TSTEP);
            6'd7:  u = u_sh(SH_20, 1'b1);
            6'd8:  u = u_dst(DST_T);
            // heading += rnd(q/pi scaled)
            6'd9:  u = u_mul(OPA_T, OPB_INVPI);
            6'd10: u = u_sh(SH_ANG, 1'b1);
            6'd11: u = u_dst(DST_HEAD);
            // travel step: vd = rnd(R*S*T >> 17)
            6'd12: u = u_mul(OPA_RADIUS, OPB_SUM);
            6'd13: u = u_sh(SH_0, 1'b0);
            6'd14: u = u_dst(DST_T);
            6'd15: u = u_mul(OPA_T, OPB_TSTEP);
            6'd16: u = u_sh(SH_17, 1'b1);
            6'd17: u = u_dst(DST_VD);
            // trig routine, run for cos then sin
            6'd18: u = u_dst(DST_FOLD);
            6'd19: u = u_mul(OPA_Z, OPB_Z);
            6'd20: u = u_sh(SH_30, 1'b0);
            6'd21: u = u_dst(DST_Z2);
            6'd22: u = u_mul(OPA_Z2, OPB_C);
            6'd23: u = u_sh(SH_30, 1'b0);
            6'd24: u = u_dst(DST_TB);
            6'd25: u = u_mul(OPA_Z2, OPB_T);
            6'd26: u = u_sh(SH_30, 1'b0);
            6'd27: u = u_dst(DST_TA);
            6'd28: u = u_mul(OPA_Z, OPB_T);
            6'd29: u = u_sh(SH_30, 1'b1);
            6'd30: u = u_dst(DST_T);
            // position step
            6'd31: u = u_mul(OPA_VD, OPB_T);
            6'd32: u = u_sh(SH_38, 1'b1);
            6'd33: begin
                u        = u_dst(DST_ACC);
                u.sq     = SQ_LOOP;
                u.target = UPC_TRIG;
            end
            6'd34: u.sq = SQ_DONE;
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

### design/ddo_sequencer.sv
// ----------------------------------------------------------------------------
// ddo_sequencer: microcode step counter for the odometry core
// Accepts an input word, steps the microprogram, runs the trig routine twice
// through one conditional jump, and hands off when the output register frees.
// ----------------------------------------------------------------------------
module ddo_sequencer import ddo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_free,
    output logic    o_done,
    output t_dp_ctl o_ctl
);

    t_seq_state r_state, n_state;
    t_upc       r_pc, n_pc;
    logic       r_pass, n_pass;
    t_uop       uop;

    // control word lookup
    always_comb begin
        uop = ddo_ucode(r_pc);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_pass  = r_pass;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                    n_pass  = 1'b0;
                end
            end
            ST_RUN: begin
                unique case (uop.sq)
                    SQ_NEXT: n_pc = r_pc + t_upc'(1);
                    SQ_LOOP: begin
                        if (!r_pass) begin
                            n_pc   = uop.target;
                            n_pass = 1'b1;
                        end else begin
                            n_pc = r_pc + t_upc'(1);
                        end
                    end
                    SQ_DONE: begin
                        if (i_out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_ctl.load = 1'b0;
        o_ctl.pass = r_pass;
        o_ctl.uop  = UOP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            ST_RUN: begin
                o_ctl.uop = uop;
                o_done    = (uop.sq == SQ_DONE) && i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_pass  <= n_pass;
        end
    end

    // an accepted word starts the program at its first step on the cos pass
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=>
            (r_state == ST_RUN && r_pc == '0 && !r_pass))
        else $error("sequencer did not start program on accept");

    // the step counter never runs past the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pc <= UPC_LAST))
        else $error("step counter outside program");

    // the sin pass begins only from the loop step
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pass) |-> ($past(r_pc) == UPC_LOOP))
        else $error("pass flag set outside loop step");

    // after hand-off the sequencer is back in idle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ST_IDLE))
        else $error("sequencer kept running after hand-off");

endmodule

### design/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath: shared multiplier, rounder and accumulators
// One signed multiplier with a product register, a rounding shifter with its
// own register, working registers, heading and saturating x/y accumulators.
// ----------------------------------------------------------------------------
module ddo_datapath import ddo_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_ctl                  i_ctl,
    input  logic signed [15:0]       i_right_speed,
    input  logic signed [15:0]       i_left_speed,
    input  logic [CFG_W-1:0]         i_wheel_radius,
    input  logic [CFG_W-1:0]         i_inverse_track,
    input  logic [CFG_W-1:0]         i_time_step,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [HDG_W-1:0]  o_heading
);

    localparam int ANG_SHIFT = ANG_SHIFT_BASE - ANGLE_BITS;
    localparam int ACC_W     = OP_W + 1;

    // working registers
    logic signed [SPD_W-1:0]  r_d, r_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OP_W-1:0]   r_sh;
    logic signed [OP_W-1:0]   r_t;
    logic signed [OP_W-1:0]   r_vd;
    logic signed [Z_W-1:0]    r_z;
    logic signed [Z_W-1:0]    r_z2;
    logic [ANGLE_BITS-1:0]    r_head;
    logic signed [POS_W-1:0]  r_acc_x, r_acc_y;

    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [2*OP_W-1:0] full;
    logic [SHA_W-1:0]         sh_amt;
    logic signed [PROD_W-1:0] half, rsum, shifted;
    logic [31:0]              a32, ang_sel;
    logic signed [Z_W:0]      ang33, fold_w;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [POS_W-1:0]  acc_sel, acc_sat;

    // operand A select
    always_comb begin
        unique case (i_ctl.uop.opa)
            OPA_RADIUS: op_a = {{(OP_W-CFG_W){1'b0}}, i_wheel_radius};
            OPA_T:      op_a = r_t;
            OPA_Z:      op_a = OP_W'(r_z);
            OPA_Z2:     op_a = OP_W'(r_z2);
            OPA_VD:     op_a = r_vd;
            default:    op_a = '0;
        endcase
    end

    // operand B select
    always_comb begin
        unique case (i_ctl.uop.opb)
            OPB_DIFF:   op_b = OP_W'(r_d);
            OPB_SUM:    op_b = OP_W'(r_s);
            OPB_INVTRK: op_b = {{(OP_W-CFG_W){1'b0}}, i_inverse_track};
            OPB_TSTEP:  op_b = {{(OP_W-CFG_W){1'b0}}, i_time_step};
            OPB_INVPI:  op_b = INV_PI_Q30;
            OPB_Z:      op_b = OP_W'(r_z);
            OPB_C:      op_b = SIN_C;
            OPB_T:      op_b = r_t;
            default:    op_b = '0;
        endcase
    end

    assign full = op_a * op_b;

    // rounding shifter: round half up, or plain arithmetic shift
    always_comb begin
        unique case (i_ctl.uop.shs)
            SH_0:    sh_amt = SHA_W'(0);
            SH_16:   sh_amt = SHA_W'(16);
            SH_17:   sh_amt = SHA_W'(17);
            SH_20:   sh_amt = SHA_W'(20);
            SH_30:   sh_amt = SHA_W'(30);
            SH_38:   sh_amt = SHA_W'(38);
            SH_ANG:  sh_amt = SHA_W'(ANG_SHIFT);
            default: sh_amt = SHA_W'(0);
        endcase
        if (i_ctl.uop.rnd && sh_amt != '0) begin
            half = PROD_W'(64'sd1) <<< (sh_amt - SHA_W'(1));
        end else begin
            half = '0;
        end
        rsum    = r_prod + half;
        shifted = rsum >>> sh_amt;
    end

    // binary angle and fold into [-pi/2, pi/2]; pass 0 takes the cosine
    always_comb begin
        a32     = {r_head, {(32-ANGLE_BITS){1'b0}}};
        ang_sel = i_ctl.pass ? a32 : a32 + QUARTER_TURN;
        ang33   = (Z_W+1)'($signed(ang_sel));
        if (ang33 > HALF_PI_33) begin
            fold_w = PI_33 - ang33;
        end else if (ang33 < -HALF_PI_33) begin
            fold_w = -PI_33 - ang33;
        end else begin
            fold_w = ang33;
        end
    end

    // saturating accumulate for the selected axis
    always_comb begin
        acc_sel = i_ctl.pass ? r_acc_y : r_acc_x;
        acc_sum = ACC_W'(acc_sel) + ACC_W'(r_sh);
        if (acc_sum > ACC_W'(POS_MAX)) begin
            acc_sat = POS_MAX;
        end else if (acc_sum < ACC_W'(POS_MIN)) begin
            acc_sat = POS_MIN;
        end else begin
            acc_sat = acc_sum[POS_W-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_d <= SPD_W'(i_right_speed) - SPD_W'(i_left_speed);
            r_s <= SPD_W'(i_right_speed) + SPD_W'(i_left_speed);
        end
        if (i_ctl.uop.mul_en) begin
            r_prod <= full[PROD_W-1:0];
        end
        if (i_ctl.uop.sh_en) begin
            r_sh <= shifted[OP_W-1:0];
        end
        unique case (i_ctl.uop.dst)
            DST_T:    r_t  <= r_sh;
            DST_VD:   r_vd <= r_sh;
            DST_FOLD: r_z  <= fold_w[Z_W-1:0];
            DST_Z2:   r_z2 <= r_sh[Z_W-1:0];
            DST_TB:   r_t  <= SIN_B - r_sh;
            DST_TA:   r_t  <= SIN_A - r_sh;
            default: begin
            end
        endcase
    end

    // heading and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else begin
            unique case (i_ctl.uop.dst)
                DST_HEAD: r_head <= r_head + r_sh[ANGLE_BITS-1:0];
                DST_ACC: begin
                    if (i_ctl.pass) begin
                        r_acc_y <= acc_sat;
                    end else begin
                        r_acc_x <= acc_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pos_x   = r_acc_x;
    assign o_pos_y   = r_acc_y;
    assign o_heading = a32[31:32-HDG_W];

endmodule

### design/diff_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_core: differential drive odometry, top level
// Integrates wheel speed words into heading and saturating x/y position.
// ----------------------------------------------------------------------------
// Each accepted word of right/left wheel speed (Q8.8 rad/s) advances the
// heading binary angle and the Q16.16 x/y position, and produces one result
// word with x, y and heading. The microprogram steps through the word on one
// shared 34x34 multiplier, every multiply costing an issue, a rounding and a
// writeback step, with the sine routine run once for x and once for y. The
// sequencer then returns to idle before it takes the next word, so a new word
// is not taken while the previous one is in work. A new word is accepted once
// the previous one has been handed to the output register, so a result may
// wait there while the next word is already in work; the last step of that
// word holds until the output register is free again.
// Configuration writes take effect at once and belong in idle time.
module diff_drive_odometry_core import ddo_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [15:0]       i_right_speed,
    input  logic signed [15:0]       i_left_speed,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [HDG_W-1:0]  o_heading
);

    logic [CFG_W-1:0]        r_wheel_radius, r_inverse_track, r_time_step;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    logic signed [HDG_W-1:0] r_heading;
    logic                    out_free, done;
    t_dp_ctl                 ctl;
    logic signed [POS_W-1:0] dp_x, dp_y;
    logic signed [HDG_W-1:0] dp_heading;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius  <= RST_RADIUS;
            r_inverse_track <= RST_INVTRK;
            r_time_step     <= RST_TSTEP;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS: r_wheel_radius  <= i_cfg_data;
                CFG_INVTRK: r_inverse_track <= i_cfg_data;
                CFG_TSTEP:  r_time_step     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    ddo_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .o_done     (done),
        .o_ctl      (ctl)
    );

    ddo_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_right_speed   (i_right_speed),
        .i_left_speed    (i_left_speed),
        .i_wheel_radius  (r_wheel_radius),
        .i_inverse_track (r_inverse_track),
        .i_time_step     (r_time_step),
        .o_pos_x         (dp_x),
        .o_pos_y         (dp_y),
        .o_heading       (dp_heading)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_pos_x   <= dp_x;
            r_pos_y   <= dp_y;
            r_heading <= dp_heading;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_heading   = r_heading;

endmodule

### test/tb_diff_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_core: self-checking bench for the odometry core
// Sends wheel speed words through valid/ready with random gaps and output
// stalls. A fixed-point pose integrator in the bench predicts x, y and
// heading for every accepted word. Each result word is checked field by
// field in order. A directed table covers field and register extremes,
// zero radius and zero time step, the half-turn wrap and an unused register
// index. Random phases follow: mixed driving, a long straight run into
// position saturation and back out, and a stretch with no idle cycles.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_core;
    import ddo_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 80;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int HEAD_BITS      = 16;

    // Register values after reset
    localparam logic [15:0] RADIUS_AT_RESET = 16'd1966;
    localparam logic [15:0] INVTRK_AT_RESET = 16'd18204;
    localparam logic [15:0] TSTEP_AT_RESET  = 16'd1507;

    // Unused register index, writes to it must be dropped
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    // Q30 constants of the integrator: 2^30/pi and the sine polynomial
    localparam longint RECIP_PI_Q30 = 64'sd341782638;
    localparam longint POLY_A       = 64'sd1686629713;
    localparam longint POLY_B       = 64'sd688904866;
    localparam longint POLY_C       = 64'sd76016977;

    localparam longint POS_CEIL  = 64'sd2147483647;
    localparam longint POS_FLOOR = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] heading;
    } pose_t;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [1:0]         idx;
        logic [15:0]        value;
        logic signed [15:0] right;
        logic signed [15:0] left;
        logic               pinned;  // expected pose given in the row
        pose_t              pose;
    } script_row_t;

    typedef enum { DRIVE_MIX, DRIVE_CRUISE, DRIVE_REVERSE } drive_style_e;

    localparam pose_t POSE_ORIGIN    = '0;
    localparam pose_t POSE_HALF_TURN = '{32'sd0, 32'sd0, 16'sh8000};

    localparam logic signed [15:0] EDGE_SPEEDS [4] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF
    };

    // Directed words: zero radius and zero time step give no motion, the
    // half-turn row lands exactly on pi, the unused index must not disturb it
    localparam int NROWS = 25;
    localparam script_row_t SCRIPT [NROWS] = '{
        '{ROW_WORD, 2'd0, 16'd0, 16'sh0000, 16'sh0000, 1'b1, POSE_ORIGIN},
        '{ROW_REG, CFG_RADIUS, 16'd0, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh7FFF, 16'sh8000, 1'b1, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh8000, 16'sh8000, 1'b1, POSE_ORIGIN},
        '{ROW_REG, CFG_RADIUS, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_REG, CFG_TSTEP, 16'd0, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh7FFF, 16'sh7FFF, 1'b1, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh8000, 16'sh7FFF, 1'b1, POSE_ORIGIN},
        '{ROW_REG, CFG_RADIUS, 16'd32758, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_REG, CFG_INVTRK, 16'd4096, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_REG, CFG_TSTEP, 16'd32768, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sd1609, -16'sd1609, 1'b1, POSE_HALF_TURN},
        '{ROW_REG, CFG_UNUSED_IDX, 16'd0, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sd1609, -16'sd1609, 1'b1, POSE_ORIGIN},
        '{ROW_REG, CFG_RADIUS, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_REG, CFG_INVTRK, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_REG, CFG_TSTEP, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh7FFF, 16'sh8000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh8000, 16'sh7FFF, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh8000, 16'sh8000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh0001, 16'sh0000, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh0000, 16'shFFFF, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'shFFFF, 16'shFFFF, 1'b0, POSE_ORIGIN},
        '{ROW_WORD, 2'd0, 16'd0, 16'sh5555, 16'shAAAA, 1'b0, POSE_ORIGIN}
    };

    // DUT signals; the driven inputs are known from time zero
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [1:0]               cfg_index   = 2'd0;
    logic [CFG_W-1:0]         cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic signed [15:0]       right_spd   = '0;
    logic signed [15:0]       left_spd    = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [HDG_W-1:0]  heading;

    // Bench copy of the registers and the integrated pose
    logic [15:0]          reg_radius;
    logic [15:0]          reg_invtrk;
    logic [15:0]          reg_tstep;
    logic signed [31:0]   odo_x;
    logic signed [31:0]   odo_y;
    logic [HEAD_BITS-1:0] odo_heading;

    pose_t pending_poses[$];
    int    mismatches = 0;
    int    gap_max    = 5;

    diff_drive_odometry_core #(
        .ANGLE_BITS (HEAD_BITS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_right_speed (right_spd),
        .i_left_speed  (left_spd),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_heading     (heading)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Round half up, then arithmetic shift right
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp_pos(input longint v);
        if (v > POS_CEIL) return POS_CEIL[31:0];
        if (v < POS_FLOOR) return POS_FLOOR[31:0];
        return v[31:0];
    endfunction

    // Sine of a 32-bit binary angle in Q2.30, folded into [-pi/2, pi/2]
    function automatic longint sine_q30(input logic [31:0] ang);
        longint z, z2, tb, ta;
        z = longint'({33'd0, ang[30:0]});
        if (ang[31]) z = z - (64'sd1 <<< 31);
        if (z > (64'sd1 <<< 30)) z = (64'sd1 <<< 31) - z;
        if (z < -(64'sd1 <<< 30)) z = -(64'sd1 <<< 31) - z;
        z2 = (z * z) >>> 30;
        tb = POLY_B - ((z2 * POLY_C) >>> 30);
        ta = POLY_A - ((z2 * tb) >>> 30);
        return round_shift(z * ta, 30);
    endfunction

    // Advance the pose by one speed word and return the new pose
    function automatic pose_t integrate_sample(input logic signed [15:0] rs,
                                               input logic signed [15:0] ls);
        longint wr, wl, r, t, turn, rad_step, dang, travel, c, s;
        logic [31:0] a32;
        pose_t pose;
        wr = longint'(rs);
        wl = longint'(ls);
        r  = longint'(reg_radius);
        t  = longint'(reg_tstep);

        // heading first
        turn     = round_shift(r * (wr - wl) * longint'(reg_invtrk), 16);
        rad_step = round_shift(turn * t, 20);
        dang     = round_shift(rad_step * RECIP_PI_Q30, 47 - HEAD_BITS);
        odo_heading = odo_heading + dang[HEAD_BITS-1:0];
        a32 = 32'(odo_heading) << (32 - HEAD_BITS);

        // then travel along the new heading
        travel = round_shift(r * (wr + wl) * t, 17);
        c = sine_q30(a32 + 32'h4000_0000);
        s = sine_q30(a32);
        odo_x = clamp_pos(longint'(odo_x) + round_shift(travel * c, 38));
        odo_y = clamp_pos(longint'(odo_y) + round_shift(travel * s, 38));

        pose.x       = odo_x;
        pose.y       = odo_y;
        pose.heading = a32[31:16];
        return pose;
    endfunction

    // Offer one word; called and returning at a falling edge
    task automatic offer_word(input logic signed [15:0] rs, input logic signed [15:0] ls,
                              input logic pinned, input pose_t pinned_pose);
        int    gap;
        pose_t model;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        right_spd = rs;
        left_spd  = ls;
        in_valid  = 1'b1;
        do @(posedge clk); while (!in_ready);
        model = integrate_sample(rs, ls);
        pending_poses.push_back(pinned ? pinned_pose : model);
        @(negedge clk);
    endtask

    // Wait for every expected word so registers change only while idle
    task automatic settle();
        in_valid = 1'b0;
        while (pending_poses.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_RADIUS: reg_radius = value;
            CFG_INVTRK: reg_invtrk = value;
            CFG_TSTEP:  reg_tstep  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] rad, input logic [15:0] inv,
                             input logic [15:0] stp);
        settle();
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_INVTRK, inv);
        write_reg(CFG_TSTEP, stp);
    endtask

    function automatic logic [15:0] extreme_or_random();
        case ($urandom_range(0, 2))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random speed words: straight runs, spins, crawling, extremes and noise
    task automatic run_drive(input int count, input drive_style_e style);
        int                 k, sel;
        logic signed [15:0] rs, ls, base;
        for (k = 0; k < count; k++) begin
            sel  = $urandom_range(0, 99);
            base = 16'($urandom);
            case (style)
                DRIVE_CRUISE: begin
                    rs = 16'sh7FFF - 16'($urandom_range(0, 255));
                    ls = rs;
                end
                DRIVE_REVERSE: begin
                    rs = 16'sh8000 + 16'($urandom_range(0, 255));
                    ls = rs;
                end
                default: begin
                    if (sel < 35) begin
                        rs = 16'($urandom);
                        ls = 16'($urandom);
                    end else if (sel < 60) begin
                        rs = base;
                        ls = base + 16'($urandom_range(0, 15)) - 16'd8;
                    end else if (sel < 75) begin
                        rs = base;
                        ls = -base;
                    end else if (sel < 90) begin
                        rs = 16'($urandom_range(0, 511)) - 16'd256;
                        ls = 16'($urandom_range(0, 511)) - 16'd256;
                    end else begin
                        rs = EDGE_SPEEDS[$urandom_range(0, 3)];
                        ls = EDGE_SPEEDS[$urandom_range(0, 3)];
                    end
                end
            endcase
            offer_word(rs, ls, 1'b0, POSE_ORIGIN);
        end
    endtask

    // Output side: random stalls per word, two long holds to back up the input
    initial begin : drain_results
        int stall;
        int rx_words;
        rx_words = 0;
        forever begin
            if (rx_words == 150 || rx_words == 900) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = $urandom_range(0, gap_max);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            rx_words++;
            @(negedge clk);
        end
    end

    function automatic void flag_field(input string field, input longint want,
                                       input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result word with the oldest expected pose
    always @(posedge clk) begin : check_results
        pose_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_poses.size() == 0) begin
                $display("%0t: unexpected result word x=%0d y=%0d heading=%0d",
                         $time, pos_x, pos_y, heading);
                mismatches++;
            end else begin
                want = pending_poses.pop_front();
                flag_field("pos_x", $signed(want.x), pos_x);
                flag_field("pos_y", $signed(want.y), pos_y);
                flag_field("heading", $signed(want.heading), heading);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[diff_drive_odometry_core] ERROR");
        $finish;
    end

    initial begin : stimulus
        int n;
        reg_radius  = RADIUS_AT_RESET;
        reg_invtrk  = INVTRK_AT_RESET;
        reg_tstep   = TSTEP_AT_RESET;
        odo_x       = '0;
        odo_y       = '0;
        odo_heading = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (n = 0; n < NROWS; n++) begin
            if (SCRIPT[n].kind == ROW_REG) begin
                settle();
                write_reg(SCRIPT[n].idx, SCRIPT[n].value);
            end else begin
                offer_word(SCRIPT[n].right, SCRIPT[n].left, SCRIPT[n].pinned,
                           SCRIPT[n].pose);
            end
        end

        // random phases
        load_regs(RADIUS_AT_RESET, INVTRK_AT_RESET, TSTEP_AT_RESET);
        run_drive(120, DRIVE_MIX);
        load_regs(16'($urandom), 16'($urandom), 16'($urandom));
        run_drive(120, DRIVE_MIX);

        // full-scale straight run into saturation, then back off the limit
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_drive(650, DRIVE_CRUISE);
        run_drive(120, DRIVE_REVERSE);

        // back-to-back words with no idle cycles on either side
        load_regs(16'($urandom), 16'($urandom), 16'($urandom));
        gap_max = 0;
        run_drive(120, DRIVE_MIX);
        gap_max = 5;

        repeat (2) begin
            load_regs(extreme_or_random(), extreme_or_random(), extreme_or_random());
            run_drive(120, DRIVE_MIX);
        end

        in_valid = 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[diff_drive_odometry_core] OK");
        end else begin
            $display("[diff_drive_odometry_core] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/ddo_pkg.sv
design/ddo_sequencer.sv
design/ddo_datapath.sv
design/diff_drive_odometry_core.sv
test/tb_diff_drive_odometry_core.sv
